@@ rtl/core/pat_pkg.sv @@
package pat_pkg;

  localparam int POS_FRAC_BITS = 8;
  localparam int POS_W = 20;
  localparam int ATT_W = 12;
  localparam int COL_W = 8;

  localparam int AW  = ATT_W + POS_FRAC_BITS;
  localparam int DW  = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int MW  = DW;
  localparam int RW  = MW + 1;
  localparam int NW  = 2 * RW;
  localparam int QW  = POS_FRAC_BITS + 1;
  localparam int SPW = QW + 1;
  localparam int SW  = POS_W + 2;
  localparam int CW  = SW + COL_W;
  localparam int TD_W = ((4 * POS_W + 2 * ATT_W + 7) / 8) * 8;
  localparam int OD_W = ((4 * POS_W + 3 * COL_W + 7) / 8) * 8;

  localparam logic [CW-1:0] GREEN_NUM = CW'(1020) << POS_FRAC_BITS;
  localparam logic [CW-1:0] BLUE_NUM  = CW'(255) << (POS_FRAC_BITS - 1);
  localparam logic [COL_W-1:0] COL_MAX = '1;

  localparam logic signed [POS_W+1:0] SAT_HI = (POS_W+2)'(2 ** (POS_W - 1) - 1);
  localparam logic signed [POS_W+1:0] SAT_LO = -(POS_W+2)'(2 ** (POS_W - 1));

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] qx;
    logic signed [POS_W-1:0] qy;
    logic [MW-1:0]           adx;
    logic [MW-1:0]           ady;
    logic                    neg_x;
    logic                    neg_y;
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic signed [POS_W-1:0] mx;
    logic signed [POS_W-1:0] my;
  } posn_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[POS_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/particle_attraction_step.sv @@
// Particle attraction step, one particle per item, no state between items.
// Input channel in_*: tdata holds pos_x, pos_y, prev_x, prev_y (20 bits each,
// signed Q.8) then attractor_x, attractor_y (12 bits each, whole pixels).
// Output channel out_*: tdata holds next_x, next_y, next_prev_x, next_prev_y
// (20 bits each, signed Q.8, saturated) then red, green, blue (8 bits each).
// Throughput: one item per cycle unless the output stalls, fully pipelined.
// Pipeline from input accept to output valid: 3 front stages
// (offset, squares, sum), 22 stages of the bit-serial square root, 9 stages
// of the step divider, 3 stages for move/velocity/next and 9 stages of the
// colour dividers, whose last stage is the output register.
// The pipeline moves as a whole: when out_tvalid is high and out_tready is
// low, every stage holds and in_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module particle_attraction_step
  import pat_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // pos_x, pos_y, prev_x, prev_y, attractor_x, attractor_y
  input  logic [TD_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // next_x, next_y, next_prev_x, next_prev_y, red, green, blue
  output logic [OD_W-1:0] out_tdata
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [POS_W-1:0] in_px, in_py, in_qx, in_qy;
  logic signed [ATT_W-1:0] in_ax, in_ay;
  logic signed [DW-1:0]    dx, dy;
  side_t                   side_a_nxt;

  assign in_px = in_tdata[POS_W-1:0];
  assign in_py = in_tdata[2*POS_W-1:POS_W];
  assign in_qx = in_tdata[3*POS_W-1:2*POS_W];
  assign in_qy = in_tdata[4*POS_W-1:3*POS_W];
  assign in_ax = in_tdata[4*POS_W+ATT_W-1:4*POS_W];
  assign in_ay = in_tdata[4*POS_W+2*ATT_W-1:4*POS_W+ATT_W];

  assign dx = DW'($signed({in_ax, {POS_FRAC_BITS{1'b0}}})) - DW'(in_px);
  assign dy = DW'($signed({in_ay, {POS_FRAC_BITS{1'b0}}})) - DW'(in_py);

  always_comb begin
    side_a_nxt.px    = in_px;
    side_a_nxt.py    = in_py;
    side_a_nxt.qx    = in_qx;
    side_a_nxt.qy    = in_qy;
    side_a_nxt.neg_x = dx[DW-1];
    side_a_nxt.neg_y = dy[DW-1];
    side_a_nxt.adx   = dx[DW-1] ? MW'(-dx) : MW'(dx);
    side_a_nxt.ady   = dy[DW-1] ? MW'(-dy) : MW'(dy);
  end

  logic              vld_a_r, vld_b_r, vld_c_r;
  side_t             side_a_r, side_b_r, side_c_r;
  logic [2*MW-1:0]   sqx_r, sqy_r;
  logic [NW-1:0]     n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_tvalid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r <= side_a_nxt;
      side_b_r <= side_a_r;
      sqx_r    <= (2*MW)'(side_a_r.adx) * (2*MW)'(side_a_r.adx);
      sqy_r    <= (2*MW)'(side_a_r.ady) * (2*MW)'(side_a_r.ady);
      side_c_r <= side_b_r;
      n_r      <= NW'(sqx_r) + NW'(sqy_r);
    end
  end

  logic          vld_s;
  logic [RW-1:0] root_s;
  side_t         side_s;

  pat_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_c_r),
    .n_i    (n_r),
    .side_i (side_c_r),
    .vld_o  (vld_s),
    .root_o (root_s),
    .side_o (side_s)
  );

  logic                  vld_d;
  logic signed [SPW-1:0] step_x, step_y;
  side_t                 side_d;

  pat_stepdiv u_stepdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (vld_s),
    .root_i   (root_s),
    .side_i   (side_s),
    .vld_o    (vld_d),
    .step_x_o (step_x),
    .step_y_o (step_y),
    .side_o   (side_d)
  );

  logic                    vld_m_r, vld_v_r, vld_n_r;
  logic signed [POS_W-1:0] mx_m_r, my_m_r, qx_m_r, qy_m_r;
  logic signed [POS_W-1:0] mx_v_r, my_v_r;
  logic signed [POS_W:0]   vx_v_r, vy_v_r;
  posn_t                   posn_n_r;
  logic [SW-1:0]           s_n_r;
  logic signed [SW-1:0]    vs;

  assign vs = SW'(vx_v_r) + SW'(vy_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_v_r <= 1'b0;
      vld_n_r <= 1'b0;
    end else if (en) begin
      vld_m_r <= vld_d;
      vld_v_r <= vld_m_r;
      vld_n_r <= vld_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_m_r <= sat_pos((POS_W+2)'(side_d.px) + (POS_W+2)'(step_x));
      my_m_r <= sat_pos((POS_W+2)'(side_d.py) + (POS_W+2)'(step_y));
      qx_m_r <= side_d.qx;
      qy_m_r <= side_d.qy;
      mx_v_r <= mx_m_r;
      my_v_r <= my_m_r;
      vx_v_r <= (POS_W+1)'(mx_m_r) - (POS_W+1)'(qx_m_r);
      vy_v_r <= (POS_W+1)'(my_m_r) - (POS_W+1)'(qy_m_r);
      posn_n_r.mx <= mx_v_r;
      posn_n_r.my <= my_v_r;
      posn_n_r.nx <= sat_pos((POS_W+2)'(mx_v_r) + (POS_W+2)'(vx_v_r));
      posn_n_r.ny <= sat_pos((POS_W+2)'(my_v_r) + (POS_W+2)'(vy_v_r));
      s_n_r       <= vs[SW-1] ? SW'(-vs) : SW'(vs);
    end
  end

  posn_t            posn_o;
  logic [COL_W-1:0] red, green, blue;

  pat_colour u_colour (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (vld_n_r),
    .s_i     (s_n_r),
    .posn_i  (posn_n_r),
    .vld_o   (out_tvalid),
    .posn_o  (posn_o),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign out_tdata = OD_W'({blue, green, red, posn_o.my, posn_o.mx, posn_o.ny, posn_o.nx});

endmodule

@@ rtl/core/pat_isqrt.sv @@
module pat_isqrt
  import pat_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] n_i,
  input  side_t         side_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output side_t         side_o
);

  localparam int RMW = RW + 3;

  logic           vld_r  [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [NW-1:0]  n_r    [RW];
  side_t          side_r [RW];
  logic [RMW-1:0] rem_nxt  [RW];
  logic [RW-1:0]  root_nxt [RW];

  // one root bit per stage, two radicand bits consumed
  always_comb begin
    logic [RMW-1:0] rem_in;
    logic [RMW-1:0] sh;
    logic [RMW-1:0] tr;
    logic [RW-1:0]  root_in;
    logic [NW-1:0]  n_in;
    for (int i = 0; i < RW; i++) begin
      if (i == 0) begin
        rem_in  = '0;
        root_in = '0;
        n_in    = n_i;
      end else begin
        rem_in  = rem_r[i-1];
        root_in = root_r[i-1];
        n_in    = n_r[i-1];
      end
      sh = {rem_in[RMW-3:0], n_in[2*(RW-1-i)+1 -: 2]};
      tr = RMW'({root_in, 2'b01});
      if (sh >= tr) begin
        rem_nxt[i]  = sh - tr;
        root_nxt[i] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = sh;
        root_nxt[i] = {root_in[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RW; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < RW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= n_i;
      side_r[0] <= side_i;
      for (int i = 1; i < RW; i++) begin
        n_r[i]    <= n_r[i-1];
        side_r[i] <= side_r[i-1];
      end
      for (int i = 0; i < RW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

@@ rtl/core/pat_stepdiv.sv @@
module pat_stepdiv
  import pat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [RW-1:0]         root_i,
  input  side_t                 side_i,
  output logic                  vld_o,
  output logic signed [SPW-1:0] step_x_o,
  output logic signed [SPW-1:0] step_y_o,
  output side_t                 side_o
);

  localparam int RCW = RW + QW;

  logic           vld_r  [QW];
  logic [RCW-1:0] remx_r [QW];
  logic [RCW-1:0] remy_r [QW];
  logic [QW-1:0]  qx_r   [QW];
  logic [QW-1:0]  qy_r   [QW];
  logic [RW-1:0]  div_r  [QW];
  side_t          side_r [QW];
  logic [RCW-1:0] remx_nxt [QW];
  logic [RCW-1:0] remy_nxt [QW];
  logic [QW-1:0]  qx_nxt   [QW];
  logic [QW-1:0]  qy_nxt   [QW];

  // restoring division, quotient bit QW-1-i in stage i
  always_comb begin
    logic [RCW-1:0] rx;
    logic [RCW-1:0] ry;
    logic [RCW-1:0] dv;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qy;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rx = RCW'(side_i.adx) << POS_FRAC_BITS;
        ry = RCW'(side_i.ady) << POS_FRAC_BITS;
        qx = '0;
        qy = '0;
        dv = RCW'(root_i) << (QW - 1 - i);
      end else begin
        rx = remx_r[i-1];
        ry = remy_r[i-1];
        qx = qx_r[i-1];
        qy = qy_r[i-1];
        dv = RCW'(div_r[i-1]) << (QW - 1 - i);
      end
      if (rx >= dv) begin
        remx_nxt[i] = rx - dv;
        qx_nxt[i]   = qx | (QW'(1) << (QW - 1 - i));
      end else begin
        remx_nxt[i] = rx;
        qx_nxt[i]   = qx;
      end
      if (ry >= dv) begin
        remy_nxt[i] = ry - dv;
        qy_nxt[i]   = qy | (QW'(1) << (QW - 1 - i));
      end else begin
        remy_nxt[i] = ry;
        qy_nxt[i]   = qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < QW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]  <= root_i;
      side_r[0] <= side_i;
      for (int i = 1; i < QW; i++) begin
        div_r[i]  <= div_r[i-1];
        side_r[i] <= side_r[i-1];
      end
      for (int i = 0; i < QW; i++) begin
        remx_r[i] <= remx_nxt[i];
        remy_r[i] <= remy_nxt[i];
        qx_r[i]   <= qx_nxt[i];
        qy_r[i]   <= qy_nxt[i];
      end
    end
  end

  logic signed [SPW-1:0] magx;
  logic signed [SPW-1:0] magy;
  logic                  dz;

  assign magx   = $signed({1'b0, qx_r[QW-1]});
  assign magy   = $signed({1'b0, qy_r[QW-1]});
  assign dz     = (div_r[QW-1] == '0);
  // on the attractor: no step
  assign step_x_o = dz ? '0 : (side_r[QW-1].neg_x ? -magx : magx);
  assign step_y_o = dz ? '0 : (side_r[QW-1].neg_y ? -magy : magy);
  assign vld_o    = vld_r[QW-1];
  assign side_o   = side_r[QW-1];

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && !dz) |-> (qx_r[QW-1] <= (QW'(1) << POS_FRAC_BITS)) &&
                       (qy_r[QW-1] <= (QW'(1) << POS_FRAC_BITS)))
    else $error("step exceeds one unit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && !dz) |-> (remx_r[QW-1] < RCW'(div_r[QW-1])) &&
                       (remy_r[QW-1] < RCW'(div_r[QW-1])))
    else $error("step remainder not below distance");

endmodule

@@ rtl/core/pat_colour.sv @@
module pat_colour
  import pat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [SW-1:0]    s_i,
  input  posn_t            posn_i,
  output logic             vld_o,
  output posn_t            posn_o,
  output logic [COL_W-1:0] red_o,
  output logic [COL_W-1:0] green_o,
  output logic [COL_W-1:0] blue_o
);

  localparam int NS = COL_W + 1;

  logic             vld_r  [NS];
  logic [SW-1:0]    s_r    [NS];
  logic [CW-1:0]    remg_r [NS];
  logic [CW-1:0]    remb_r [NS];
  logic [COL_W-1:0] qg_r   [NS];
  logic [COL_W-1:0] qb_r   [NS];
  logic             gcl_r  [NS];
  logic             bcl_r  [NS];
  logic [COL_W-1:0] red_r  [NS];
  posn_t            posn_r [NS];
  logic [CW-1:0]    remg_nxt [NS];
  logic [CW-1:0]    remb_nxt [NS];
  logic [COL_W-1:0] qg_nxt   [NS];
  logic [COL_W-1:0] qb_nxt   [NS];
  logic [COL_W-1:0] red_nxt;

  logic [SW+COL_W-1:0] prod;
  logic [SW+COL_W-1:0] rsh;

  assign prod = (SW+COL_W)'(s_i) * (SW+COL_W)'(255);
  assign rsh  = prod >> (POS_FRAC_BITS + 2);
  assign red_nxt = (rsh > (SW+COL_W)'(COL_MAX)) ? COL_MAX : rsh[COL_W-1:0];

  // stage 0 clamps, stages 1..COL_W give one quotient bit each
  always_comb begin
    logic [CW-1:0] dv;
    remg_nxt[0] = GREEN_NUM;
    remb_nxt[0] = BLUE_NUM;
    qg_nxt[0]   = '0;
    qb_nxt[0]   = '0;
    for (int i = 1; i < NS; i++) begin
      dv = CW'(s_r[i-1]) << (COL_W - i);
      if (remg_r[i-1] >= dv) begin
        remg_nxt[i] = remg_r[i-1] - dv;
        qg_nxt[i]   = qg_r[i-1] | (COL_W'(1) << (COL_W - i));
      end else begin
        remg_nxt[i] = remg_r[i-1];
        qg_nxt[i]   = qg_r[i-1];
      end
      if (remb_r[i-1] >= dv) begin
        remb_nxt[i] = remb_r[i-1] - dv;
        qb_nxt[i]   = qb_r[i-1] | (COL_W'(1) << (COL_W - i));
      end else begin
        remb_nxt[i] = remb_r[i-1];
        qb_nxt[i]   = qb_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]    <= s_i;
      posn_r[0] <= posn_i;
      red_r[0]  <= red_nxt;
      gcl_r[0]  <= (CW'(s_i) << COL_W) <= GREEN_NUM;
      bcl_r[0]  <= (CW'(s_i) << COL_W) <= BLUE_NUM;
      for (int i = 1; i < NS; i++) begin
        s_r[i]    <= s_r[i-1];
        posn_r[i] <= posn_r[i-1];
        red_r[i]  <= red_r[i-1];
        gcl_r[i]  <= gcl_r[i-1];
        bcl_r[i]  <= bcl_r[i-1];
      end
      for (int i = 0; i < NS; i++) begin
        remg_r[i] <= remg_nxt[i];
        remb_r[i] <= remb_nxt[i];
        qg_r[i]   <= qg_nxt[i];
        qb_r[i]   <= qb_nxt[i];
      end
    end
  end

  assign vld_o   = vld_r[NS-1];
  assign posn_o  = posn_r[NS-1];
  assign red_o   = red_r[NS-1];
  assign green_o = gcl_r[NS-1] ? COL_MAX : qg_r[NS-1];
  assign blue_o  = bcl_r[NS-1] ? COL_MAX : qb_r[NS-1];

  a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && s_r[NS-1] == '0) |-> (red_o == '0) && gcl_r[NS-1] && bcl_r[NS-1])
    else $error("zero velocity colour wrong");

  a_clamp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && bcl_r[NS-1]) |-> gcl_r[NS-1])
    else $error("blue clamps without green");

  a_green_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && !gcl_r[NS-1]) |-> (remg_r[NS-1] < CW'(s_r[NS-1])))
    else $error("green remainder not below divisor");

endmodule

@@ tb/tb_particle_attraction_step.sv @@
module tb_particle_attraction_step;
  import pat_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TD_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OD_W-1:0] out_tdata;

  typedef struct packed {
    logic signed [POS_W-1:0] px, py, qx, qy;
    logic signed [ATT_W-1:0] ax, ay;
  } particle_t;

  typedef struct packed {
    logic [POS_W-1:0] nx, ny, mx, my;
    logic [COL_W-1:0] r, g, b;
  } update_t;

  particle_t pending_q[$];
  update_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit hold_sender = 1'b0;

  always #10 clk = ~clk;

  particle_attraction_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic update_t attract_particle(particle_t p);
    longint unit_q, dx, dy, sx, sy, mx, my, vx, vy, vs;
    longint unsigned dist_q, s, r, g, b;
    update_t u;
    unit_q = 64'sd1 << POS_FRAC_BITS;
    dx = longint'(p.ax) * unit_q - longint'(p.px);
    dy = longint'(p.ay) * unit_q - longint'(p.py);
    dist_q = root_floor(dx * dx + dy * dy);
    sx = 0;
    sy = 0;
    if (dist_q != 0) begin
      sx = (dx * unit_q) / longint'(dist_q);
      sy = (dy * unit_q) / longint'(dist_q);
    end
    mx = clamp_pos(longint'(p.px) + sx);
    my = clamp_pos(longint'(p.py) + sy);
    vx = mx - longint'(p.qx);
    vy = my - longint'(p.qy);
    vs = vx + vy;
    s = (vs < 0) ? -vs : vs;
    r = (255 * s) >> (POS_FRAC_BITS + 2);
    if (s == 0) begin
      g = 255;
      b = 255;
    end else begin
      g = (1020 * unit_q) / s;
      b = (255 * unit_q) / (2 * s);
    end
    u.nx = POS_W'(clamp_pos(mx + vx));
    u.ny = POS_W'(clamp_pos(my + vy));
    u.mx = POS_W'(mx);
    u.my = POS_W'(my);
    u.r = (r > 255) ? 8'd255 : COL_W'(r);
    u.g = (g > 255) ? 8'd255 : COL_W'(g);
    u.b = (b > 255) ? 8'd255 : COL_W'(b);
    return u;
  endfunction

  function automatic logic [TD_W-1:0] pack_particle(particle_t p);
    logic [TD_W-1:0] d;
    d = '0;
    d[19:0] = p.px;
    d[39:20] = p.py;
    d[59:40] = p.qx;
    d[79:60] = p.qy;
    d[91:80] = p.ax;
    d[103:92] = p.ay;
    return d;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  task automatic queue_particle(particle_t p);
    pending_q.push_back(p);
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2: return POS_W'($urandom_range(0, 4095) - 2048);
      default: return POS_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
    end else if (send_wait > 0 || hold_sender) begin
      if (in_tvalid) begin
        expected_q.push_back(attract_particle(pending_q.pop_front()));
      end
      in_tvalid <= 1'b0;
      if (send_wait > 0) send_wait--;
    end else begin
      if (in_tvalid) begin
        expected_q.push_back(attract_particle(pending_q.pop_front()));
        send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
      if (in_tvalid && send_wait > 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_particle(pending_q[0]);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    update_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = update_t'(out_tdata[OD_W-1:0]);
        got.nx = out_tdata[19:0];
        got.ny = out_tdata[39:20];
        got.mx = out_tdata[59:40];
        got.my = out_tdata[79:60];
        got.r = out_tdata[87:80];
        got.g = out_tdata[95:88];
        got.b = out_tdata[103:96];
        if (expected_q.size() == 0) begin
          $display("unexpected item on output");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.nx !== want.nx) report_mismatch("next_x", got.nx, want.nx);
          if (got.ny !== want.ny) report_mismatch("next_y", got.ny, want.ny);
          if (got.mx !== want.mx) report_mismatch("next_prev_x", got.mx, want.mx);
          if (got.my !== want.my) report_mismatch("next_prev_y", got.my, want.my);
          if (got.r !== want.r) report_mismatch("red", got.r, want.r);
          if (got.g !== want.g) report_mismatch("green", got.g, want.g);
          if (got.b !== want.b) report_mismatch("blue", got.b, want.b);
        end
        recv_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
      if (recv_wait > 0) begin
        out_tready <= 1'b0;
        recv_wait--;
      end else begin
        out_tready <= 1'b1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    particle_t p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    p = '{px: 20'sh7FFFF, py: 20'sh7FFFF, qx: 20'sh80000, qy: 20'sh80000, ax: 12'sh7FF, ay: 12'sh7FF};
    queue_particle(p);
    p = '{px: 20'sh80000, py: 20'sh80000, qx: 20'sh7FFFF, qy: 20'sh7FFFF, ax: 12'sh800, ay: 12'sh800};
    queue_particle(p);
    p = '{px: 20'sd2560, py: -20'sd768, qx: 20'sd2560, qy: -20'sd768, ax: 12'sd10, ay: -12'sd3};
    queue_particle(p);
    p = '{px: 20'sd2560, py: -20'sd768, qx: 20'sd0, qy: 20'sd0, ax: 12'sd10, ay: -12'sd3};
    queue_particle(p);
    p = '{px: 20'sd100, py: 20'sd100, qx: 20'sd100, qy: 20'sd100, ax: 12'sd0, ay: 12'sd0};
    queue_particle(p);
    p = '{px: 20'sd0, py: 20'sd0, qx: 20'sd0, qy: 20'sd0, ax: 12'sd0, ay: 12'sd0};
    queue_particle(p);
    p = '{px: 20'sh7FFFF, py: 20'sh80000, qx: 20'sh80000, qy: 20'sh7FFFF, ax: 12'sh800, ay: 12'sh7FF};
    queue_particle(p);
    p = '{px: 20'sd5, py: 20'sd0, qx: 20'sd3, qy: 20'sd0, ax: 12'sd0, ay: 12'sd0};
    queue_particle(p);
    for (int i = 0; i < 470; i++) begin
      p.px = rand_pos();
      p.py = rand_pos();
      p.ax = ATT_W'($urandom);
      p.ay = ATT_W'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        p.qx = p.px + POS_W'($urandom_range(0, 1023) - 512);
        p.qy = p.py + POS_W'($urandom_range(0, 1023) - 512);
      end else begin
        p.qx = rand_pos();
        p.qy = rand_pos();
      end
      if ($urandom_range(0, 15) == 0) begin
        p.px = POS_W'(longint'(p.ax) * 256);
        p.py = POS_W'(longint'(p.ay) * 256);
      end
      queue_particle(p);
    end
    wait (pending_q.size() == 0 && !in_tvalid);
    hold_sender = 1'b1;
    wait (expected_q.size() == 0);
    hold_sender = 1'b0;
    for (int i = 0; i < 470; i++) begin
      p.px = rand_pos();
      p.py = rand_pos();
      p.qx = rand_pos();
      p.qy = rand_pos();
      p.ax = ATT_W'($urandom);
      p.ay = ATT_W'($urandom);
      queue_particle(p);
    end
    wait (pending_q.size() == 0 && !in_tvalid);
    wait (expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
